FILE: hdl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Command and result item layouts, status codes and the per-cell control word.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned PrioW  = 16;

  // command codes carried in the command field
  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_PUSH_FULL  = 2'd3
  } status_e;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  // command item
  typedef struct packed {
    logic [1:0]              command;
    logic [ValueW-1:0]       item_value;
    logic signed [PrioW-1:0] item_priority;
    logic [ValueW-1:0]       match_value;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [1:0]        status;
    logic [ValueW-1:0] head_value;
    logic              queue_empty;
    logic [4:0]        entry_count;
  } result_t;

  // one stored entry
  typedef struct packed {
    logic [ValueW-1:0]       value;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  // control word shared by all cells
  typedef struct packed {
    op_e                     op;
    logic                    head_ins;
    logic [ValueW-1:0]       new_value;
    logic signed [PrioW-1:0] new_priority;
    logic [ValueW-1:0]       key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hdl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry, compares it with the broadcast command and takes the new
// item, its left neighbor or its right neighbor, or keeps its own entry.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter bit IsFirst = 1'b0
) (
  input  wire logic                clk_i,
  input  wire spq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                occupied_i,
  input  wire spq_pkg::entry_t     left_i,
  input  wire spq_pkg::entry_t     right_i,
  input  wire logic                ge_left_i,
  input  wire logic                seen_left_i,
  output spq_pkg::entry_t          entry_o,
  output logic                     ge_o,
  output logic                     seen_o
);

  spq_pkg::entry_t entry_q, entry_d;
  logic            lower;
  logic            match;

  // new item lands at or before this slot
  assign lower = occupied_i && (entry_q.prio < ctrl_i.new_priority);
  assign ge_o  = ctrl_i.head_ins || (!IsFirst && !lower);

  // first matching key seen at or before this slot
  assign match  = occupied_i && (entry_q.value == ctrl_i.key);
  assign seen_o = seen_left_i || match;

  // next entry selection
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      spq_pkg::OP_PUSH: begin
        if (ge_left_i) begin
          entry_d = left_i;
        end else if (ge_o) begin
          entry_d.value = ctrl_i.new_value;
          entry_d.prio  = ctrl_i.new_priority;
        end
      end
      spq_pkg::OP_POP: begin
        entry_d = right_i;
      end
      spq_pkg::OP_DELETE: begin
        if (seen_o) begin
          entry_d = right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

FILE: hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in sorted order
// Result timing: the result item appears in the cycle after its command is taken.
// Throughput: one command per cycle; every cell shifts or loads in the same cycle.
// busy is always low and the receiver cannot stall, so nothing backs up.
// Reset: asynchronous, active low; clears the count and the result strobe,
// entry storage is not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire spq_pkg::cmd_t    cmd_i,
  output logic                  done_o,
  output spq_pkg::result_t      result_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]     count_q, count_d;
  logic                done_q;
  spq_pkg::status_e    status_q, status_d;
  spq_pkg::cell_ctrl_t ctrl;
  logic                accept;
  logic                full;
  logic                empty;

  spq_pkg::entry_t     entries [CAPACITY];
  logic [CAPACITY:0]   ge_chain;
  logic [CAPACITY:0]   seen_chain;
  logic [CAPACITY-1:0] occupied;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);

  // command decode and count update
  always_comb begin
    ctrl.op           = spq_pkg::OP_HOLD;
    ctrl.head_ins     = empty || (entries[0].prio > cmd_i.item_priority);
    ctrl.new_value    = cmd_i.item_value;
    ctrl.new_priority = cmd_i.item_priority;
    ctrl.key          = cmd_i.match_value;
    count_d           = count_q;
    status_d          = spq_pkg::ST_OK;
    if (accept) begin
      unique case (cmd_i.command)
        spq_pkg::CMD_PUSH: begin
          if (full) begin
            status_d = spq_pkg::ST_PUSH_FULL;
          end else begin
            ctrl.op = spq_pkg::OP_PUSH;
            count_d = count_q + CntW'(1);
          end
        end
        spq_pkg::CMD_POP: begin
          if (empty) begin
            status_d = spq_pkg::ST_POP_EMPTY;
          end else begin
            ctrl.op = spq_pkg::OP_POP;
            count_d = count_q - CntW'(1);
          end
        end
        spq_pkg::CMD_DELETE: begin
          if (seen_chain[CAPACITY]) begin
            ctrl.op = spq_pkg::OP_DELETE;
            count_d = count_q - CntW'(1);
          end else begin
            status_d = spq_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
          ctrl.op = spq_pkg::OP_HOLD;
        end
      endcase
    end
  end

  // cell row
  assign ge_chain[0]   = 1'b0;
  assign seen_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;

    assign occupied[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_left_edge
      assign left_e = '0;
    end else begin : g_left_link
      assign left_e = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_edge
      assign right_e = '0;
    end else begin : g_right_link
      assign right_e = entries[i+1];
    end

    spq_cell #(
      .IsFirst (i == 0)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied[i]),
      .left_i      (left_e),
      .right_i     (right_e),
      .ge_left_i   (ge_chain[i]),
      .seen_left_i (seen_chain[i]),
      .entry_o     (entries[i]),
      .ge_o        (ge_chain[i+1]),
      .seen_o      (seen_chain[i+1])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= spq_pkg::ST_OK;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
      if (accept) begin
        status_q <= status_d;
      end
    end
  end

  // result item from the registered state
  logic [CntW+4:0] count_ext;
  assign count_ext = (CntW + 5)'(count_q);

  assign done_o               = done_q;
  assign result_o.status      = status_q;
  assign result_o.head_value  = empty ? '0 : entries[0].value;
  assign result_o.queue_empty = empty;
  assign result_o.entry_count = count_ext[4:0];

endmodule
`default_nettype wire

FILE: hdl/spq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches command and result ports and flags timing and status slips.
// ----------------------------------------------------------------------------
module spq_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done_o,
  input wire spq_pkg::result_t result_o
);

  // every taken item gives a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("missing result after accepted item");

  // no result without an item taken the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without accepted item");

  // an empty queue shows zero head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.queue_empty) |-> (result_o.head_value == '0))
    else $error("empty queue with nonzero head");

  // pop on empty leaves the queue empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == spq_pkg::ST_POP_EMPTY)) |-> result_o.queue_empty)
    else $error("pop on empty reported with entries held");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire
